// ===== design/qmpr_pkg.sv =====
// Shared types and constants for the quadratic minimum positive root block.
`timescale 1ns / 1ps

package qmpr_pkg;

    // Per-item flags that travel down the pipeline next to the data.
    typedef struct packed {
        logic a_neg;    // coefficient a is negative
        logic d_zero;   // discriminant is exactly zero
        logic no_root;  // discriminant is negative
        logic degen;    // coefficient a is zero
    } flags_t;

    localparam int unsigned FLAGS_W = $bits(flags_t);

endpackage

// ===== design/quadratic_min_positive_root.sv =====
// Top level of the quadratic minimum positive root solver.
`timescale 1ns / 1ps

// Each input beat carries the coefficients a, b and c of a*x^2 + b*x + c as
// signed fixed-point numbers (FRAC_BITS fraction bits in COEF_WIDTH bits), and
// each produces exactly one output beat, in order. The output gives the
// smallest strictly positive real root, truncated toward zero and saturated to
// the coefficient range, together with the count of positive roots; a zero
// coefficient a is flagged as degenerate, and a negative discriminant gives
// no root. The block takes one beat every clock cycle while the output is not
// stalled. The bit-per-stage square root has COEF_WIDTH+1 stages and the two
// parallel bit-per-stage dividers have COEF_WIDTH+FRAC_BITS+2 stages. When the
// output is stalled the whole pipeline holds, so no beat is lost or repeated; a
// result waiting in the output register holds the input off only for as long
// as the receiver keeps m_tready low.

module quadratic_min_positive_root #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0 up: coef_a, coef_b, coef_c, then zero fill.
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // Fields from bit 0 up: found, root, positive_count, degenerate, zero fill.
    output logic [((COEF_WIDTH+4+7)/8)*8-1:0]      m_tdata
);

    localparam int W      = COEF_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int DW     = 2 * W + 1;          // discriminant width
    localparam int RW     = (DW + 1) / 2;       // square root width
    localparam int SNW    = W + 3;              // signed numerator width
    localparam int MW     = W + 2;              // numerator magnitude width
    localparam int NW     = MW + F;             // scaled dividend width
    localparam int DVW    = W + 1;              // divisor 2|a| width
    localparam int FW     = qmpr_pkg::FLAGS_W;
    localparam int SQ_SBW = FW + (W + 1) + W;   // flags, -b, |a|
    localparam int OUT_TW = ((W + 4 + 7) / 8) * 8;

    logic m_tvalid_reg;

    // The whole pipeline advances together whenever the output register
    // can take a new value.
    logic adv;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // Front: magnitudes, products and discriminant.
    logic              fr_valid;
    logic [DW-1:0]     fr_disc;
    logic signed [W:0] fr_nb;
    logic [W-1:0]      fr_am;
    qmpr_pkg::flags_t  fr_flags;

    qmpr_front #(
        .W (W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_tvalid),
        .coef_a    (s_tdata[W-1:0]),
        .coef_b    (s_tdata[2*W-1:W]),
        .coef_c    (s_tdata[3*W-1:2*W]),
        .out_valid (fr_valid),
        .disc      (fr_disc),
        .neg_b     (fr_nb),
        .a_mag     (fr_am),
        .flags     (fr_flags)
    );

    // Square root of the discriminant; -b, |a| and the flags ride alongside.
    logic              sq_valid;
    logic [RW-1:0]     sq_root;
    logic [SQ_SBW-1:0] sq_sb;

    qmpr_isqrt #(
        .DW  (DW),
        .SBW (SQ_SBW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (fr_valid),
        .radicand  (fr_disc),
        .in_sb     ({fr_flags, fr_nb, fr_am}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_sb    (sq_sb)
    );

    logic              [W-1:0] sq_am;
    logic signed       [W:0]   sq_nb;
    qmpr_pkg::flags_t          sq_flags;

    assign sq_am    = sq_sb[W-1:0];
    assign sq_nb    = $signed(sq_sb[2*W:W]);
    assign sq_flags = qmpr_pkg::flags_t'(sq_sb[SQ_SBW-1:2*W+1]);

    // Numerator stage: -b - S and -b + S, split into sign and magnitude.
    // Each quotient sign is the numerator sign against the sign of a.
    logic signed [SNW-1:0] num_lo, num_hi;
    logic [SNW-1:0]        mag_lo, mag_hi;

    always_comb
    begin
        num_lo = SNW'(sq_nb) - $signed({2'b00, sq_root});
        num_hi = SNW'(sq_nb) + $signed({2'b00, sq_root});
        mag_lo = num_lo[SNW-1] ? SNW'(-num_lo) : SNW'(num_lo);
        mag_hi = num_hi[SNW-1] ? SNW'(-num_hi) : SNW'(num_hi);
    end

    logic             nm_valid_reg;
    logic [MW-1:0]    nm_lo_reg, nm_hi_reg;
    logic             nm_neg_lo_reg, nm_neg_hi_reg;
    logic [DVW-1:0]   nm_div_reg;
    qmpr_pkg::flags_t nm_flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            nm_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nm_lo_reg     <= mag_lo[MW-1:0];
            nm_hi_reg     <= mag_hi[MW-1:0];
            nm_neg_lo_reg <= num_lo[SNW-1] != sq_flags.a_neg;
            nm_neg_hi_reg <= num_hi[SNW-1] != sq_flags.a_neg;
            nm_div_reg    <= {sq_am, 1'b0};
            nm_flags_reg  <= sq_flags;
        end
    end

    // Two divider lanes, (|num| << FRAC_BITS) / 2|a|. A zero divisor only
    // occurs for degenerate items, whose quotients are ignored.
    logic                dv_valid;
    logic                dv_valid_hi;
    logic [NW-1:0]       q_lo, q_hi;
    logic [FW:0]         dv_sb_lo;
    logic                dv_sb_hi;

    qmpr_div #(
        .NW  (NW),
        .DVW (DVW),
        .SBW (FW + 1)
    ) u_div_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (nm_valid_reg),
        .dividend  ({nm_lo_reg, F'(0)}),
        .divisor   (nm_div_reg),
        .in_sb     ({nm_flags_reg, nm_neg_lo_reg}),
        .out_valid (dv_valid),
        .quotient  (q_lo),
        .out_sb    (dv_sb_lo)
    );

    qmpr_div #(
        .NW  (NW),
        .DVW (DVW),
        .SBW (1)
    ) u_div_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (nm_valid_reg),
        .dividend  ({nm_hi_reg, F'(0)}),
        .divisor   (nm_div_reg),
        .in_sb     (nm_neg_hi_reg),
        .out_valid (dv_valid_hi),
        .quotient  (q_hi),
        .out_sb    (dv_sb_hi)
    );

    // Final stage: apply signs with saturation, order the two roots and pick
    // the smallest strictly positive one. A quotient whose upper bits are not
    // all zero overflows in either direction.
    qmpr_pkg::flags_t    dv_flags;
    logic                neg_lo, neg_hi, ovf_lo, ovf_hi;
    logic signed [W-1:0] r1, r2, r_min, r_max;
    logic signed [W-1:0] root_next;
    logic [1:0]          count_next;

    assign dv_flags = qmpr_pkg::flags_t'(dv_sb_lo[FW:1]);
    assign neg_lo   = dv_sb_lo[0];
    assign neg_hi   = dv_sb_hi;
    assign ovf_lo   = |q_lo[NW-1:W-1];
    assign ovf_hi   = |q_hi[NW-1:W-1];

    always_comb
    begin
        if (neg_lo)
        begin
            r1 = ovf_lo ? $signed({1'b1, (W-1)'(0)}) : $signed(W'(0) - q_lo[W-1:0]);
        end
        else
        begin
            r1 = ovf_lo ? $signed({1'b0, {(W-1){1'b1}}}) : $signed(q_lo[W-1:0]);
        end
        if (neg_hi)
        begin
            r2 = ovf_hi ? $signed({1'b1, (W-1)'(0)}) : $signed(W'(0) - q_hi[W-1:0]);
        end
        else
        begin
            r2 = ovf_hi ? $signed({1'b0, {(W-1){1'b1}}}) : $signed(q_hi[W-1:0]);
        end

        r_min = (r1 < r2) ? r1 : r2;
        r_max = (r1 < r2) ? r2 : r1;

        root_next  = '0;
        count_next = 2'd0;
        if (dv_flags.degen || dv_flags.no_root)
        begin
            root_next  = '0;
            count_next = 2'd0;
        end
        else if (dv_flags.d_zero)
        begin
            // Single root: both lanes divided the same numerator.
            if (r1 > 0)
            begin
                root_next  = r1;
                count_next = 2'd1;
            end
        end
        else if (r_min > 0)
        begin
            root_next  = r_min;
            count_next = 2'd2;
        end
        else if (r_max > 0)
        begin
            root_next  = r_max;
            count_next = 2'd1;
        end
    end

    // Output register. Both divider lanes run in lockstep.
    logic                found_reg;
    logic signed [W-1:0] root_reg;
    logic [1:0]          count_reg;
    logic                degen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_tvalid_reg <= dv_valid && dv_valid_hi;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            found_reg <= (count_next != 2'd0);
            root_reg  <= root_next;
            count_reg <= count_next;
            degen_reg <= dv_flags.degen;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TW'({degen_reg, count_reg, root_reg, found_reg});

endmodule

// ===== design/qmpr_front.sv =====
// Front stages: coefficient magnitudes, products and the discriminant.
`timescale 1ns / 1ps

module qmpr_front #(
    parameter int W = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [W-1:0]          coef_a,
    input  logic [W-1:0]          coef_b,
    input  logic [W-1:0]          coef_c,
    output logic                  out_valid,
    output logic [2*W:0]          disc,
    output logic signed [W:0]     neg_b,
    output logic [W-1:0]          a_mag,
    output qmpr_pkg::flags_t      flags
);

    // Stage 1: magnitudes and signs.
    logic              v1_reg;
    logic [W-1:0]      am1_reg, bm1_reg, cm1_reg;
    logic signed [W:0] nb1_reg;
    logic              an1_reg, cn1_reg, cz1_reg, dg1_reg;

    // Stage 2: products.
    logic              v2_reg;
    logic [2*W-1:0]    bb2_reg, ac2_reg;
    logic [W-1:0]      am2_reg;
    logic signed [W:0] nb2_reg;
    logic              an2_reg, cn2_reg, cz2_reg, dg2_reg;

    // Stage 3: discriminant.
    logic              v3_reg;
    logic [2*W:0]      d3_reg;
    logic [W-1:0]      am3_reg;
    logic signed [W:0] nb3_reg;
    qmpr_pkg::flags_t  fl3_reg;

    logic [2*W+1:0]    ac4;
    logic [2*W+1:0]    bbx;
    logic              same_sign;
    logic              d_neg_next;
    logic [2*W+1:0]    d_wide;

    always_comb
    begin
        ac4        = {ac2_reg, 2'b00};
        bbx        = {2'b00, bb2_reg};
        same_sign  = (an2_reg == cn2_reg) && !cz2_reg;
        d_neg_next = same_sign && (ac4 > bbx);
        d_wide     = same_sign ? (bbx - ac4) : (bbx + ac4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            am1_reg <= coef_a[W-1] ? (~coef_a + 1'b1) : coef_a;
            bm1_reg <= coef_b[W-1] ? (~coef_b + 1'b1) : coef_b;
            cm1_reg <= coef_c[W-1] ? (~coef_c + 1'b1) : coef_c;
            nb1_reg <= $signed((W+1)'(0) - {coef_b[W-1], coef_b});
            an1_reg <= coef_a[W-1];
            cn1_reg <= coef_c[W-1];
            cz1_reg <= (coef_c == '0);
            dg1_reg <= (coef_a == '0);

            bb2_reg <= bm1_reg * bm1_reg;
            ac2_reg <= am1_reg * cm1_reg;
            am2_reg <= am1_reg;
            nb2_reg <= nb1_reg;
            an2_reg <= an1_reg;
            cn2_reg <= cn1_reg;
            cz2_reg <= cz1_reg;
            dg2_reg <= dg1_reg;

            d3_reg          <= d_wide[2*W:0];
            am3_reg         <= am2_reg;
            nb3_reg         <= nb2_reg;
            fl3_reg.a_neg   <= an2_reg;
            fl3_reg.d_zero  <= (d_wide == '0);
            fl3_reg.no_root <= d_neg_next;
            fl3_reg.degen   <= dg2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign disc      = d3_reg;
    assign neg_b     = nb3_reg;
    assign a_mag     = am3_reg;
    assign flags     = fl3_reg;

endmodule

// ===== design/qmpr_isqrt.sv =====
// Pipelined integer square root, one root bit resolved per stage.
`timescale 1ns / 1ps

module qmpr_isqrt #(
    parameter int DW  = 65,
    parameter int SBW = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [DW-1:0]             radicand,
    input  logic [SBW-1:0]            in_sb,
    output logic                      out_valid,
    output logic [(DW+1)/2-1:0]       root,
    output logic [SBW-1:0]            out_sb
);

    localparam int RW  = (DW + 1) / 2;
    localparam int PW  = 2 * RW;
    localparam int RMW = RW + 2;

    logic [RMW-1:0] rem_reg  [RW];
    logic [RW-1:0]  root_reg [RW];
    logic [PW-1:0]  dv_reg   [RW];
    logic [SBW-1:0] sb_reg   [RW];
    logic [RW-1:0]  v_reg;

    genvar k;
    for (k = 0; k < RW; k++)
    begin : g_stage
        logic [RMW-1:0] rem_in;
        logic [RW-1:0]  root_in;
        logic [PW-1:0]  dv_in;
        logic [SBW-1:0] sb_k;
        logic           v_in;
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] trial;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign dv_in   = PW'(radicand);
            assign sb_k    = in_sb;
            assign v_in    = in_valid;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign dv_in   = dv_reg[k-1];
            assign sb_k    = sb_reg[k-1];
            assign v_in    = v_reg[k-1];
        end

        // Bring down the next two radicand bits and try the next root bit.
        assign rem_sh = {rem_in[RMW-3:0], dv_in[PW-1:PW-2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_in[RW-2:0], ge};
                dv_reg[k]   <= {dv_in[PW-3:0], 2'b00};
                sb_reg[k]   <= sb_k;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign out_sb    = sb_reg[RW-1];

endmodule

// ===== design/qmpr_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
`timescale 1ns / 1ps

module qmpr_div #(
    parameter int NW  = 50,
    parameter int DVW = 33,
    parameter int SBW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NW-1:0]   dividend,
    input  logic [DVW-1:0]  divisor,
    input  logic [SBW-1:0]  in_sb,
    output logic            out_valid,
    output logic [NW-1:0]   quotient,
    output logic [SBW-1:0]  out_sb
);

    localparam int RMW = DVW + 1;

    logic [DVW-1:0] rem_reg [NW];
    logic [NW-1:0]  q_reg   [NW];
    logic [NW-1:0]  n_reg   [NW];
    logic [DVW-1:0] dv_reg  [NW];
    logic [SBW-1:0] sb_reg  [NW];
    logic [NW-1:0]  v_reg;

    genvar k;
    for (k = 0; k < NW; k++)
    begin : g_stage
        logic [DVW-1:0] rem_in;
        logic [NW-1:0]  q_in;
        logic [NW-1:0]  n_in;
        logic [DVW-1:0] dv_in;
        logic [SBW-1:0] sb_k;
        logic           v_in;
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] rem_sub;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign q_in   = '0;
            assign n_in   = dividend;
            assign dv_in  = divisor;
            assign sb_k   = in_sb;
            assign v_in   = in_valid;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign n_in   = n_reg[k-1];
            assign dv_in  = dv_reg[k-1];
            assign sb_k   = sb_reg[k-1];
            assign v_in   = v_reg[k-1];
        end

        // The partial remainder stays below the divisor, so DVW bits hold it.
        assign rem_sh  = {rem_in, n_in[NW-1]};
        assign ge      = (rem_sh >= {1'b0, dv_in});
        assign rem_sub = rem_sh - {1'b0, dv_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
                q_reg[k]   <= {q_in[NW-2:0], ge};
                n_reg[k]   <= {n_in[NW-2:0], 1'b0};
                dv_reg[k]  <= dv_in;
                sb_reg[k]  <= sb_k;
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign quotient  = q_reg[NW-1];
    assign out_sb    = sb_reg[NW-1];

endmodule

// ===== verif/tb_quadratic_min_positive_root.sv =====
// Stream testbench for the quadratic minimum positive root solver.
`timescale 1ns / 1ps

// The testbench drives coefficient beats into the solver and compares every output
// beat with an expected result. It starts with a table of directed cases. Rows that
// have a typed-in result are checked against that value. All other rows, and the
// random beats that follow, are checked against a local root predictor. The random
// beats come in bursts with random gaps. The receiver stalls on its own pattern, and
// once it holds off for a long stretch so that the whole pipeline stalls.

module tb_quadratic_min_positive_root;

    localparam int CW     = 32;
    localparam int FB     = 16;
    localparam int IN_W   = ((3*CW+7)/8)*8;
    localparam int OUT_W  = ((CW+4+7)/8)*8;
    localparam int LATENCY = 2*CW + FB + 8;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM = 400;
    localparam logic signed [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MIN_C = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE   = 1 <<< FB;

    typedef struct packed {
        logic                 degenerate;
        logic [1:0]           positive_count;
        logic signed [CW-1:0] root;
        logic                 found;
    } root_result_t;

    typedef struct {
        logic signed [CW-1:0] a, b, c;
        bit                   has_fixed;
        root_result_t         fixed_res;
    } coef_row_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;    // Fields from bit 0 up: coef_a, coef_b, coef_c.
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;    // Fields from bit 0 up: found, root, positive_count, degenerate.

    root_result_t pending_roots[$];
    int           fail_count = 0;
    int           idle_cycles = 0;
    bit           stim_done = 0;
    bit           long_hold = 0;

    quadratic_min_positive_root #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Truncating divide of num * 2^FB by 2a, saturated to the coefficient range.
    function automatic longint scaled_quotient(longint num, longint a);
        logic signed [127:0] n;
        logic signed [127:0] q;
        n = 128'(signed'(num)) <<< FB;
        q = n / (128'(signed'(a)) * 2);
        if (q > 128'(signed'(MAX_C)))
            return longint'(MAX_C);
        if (q < 128'(signed'(MIN_C)))
            return longint'(MIN_C);
        return longint'(q);
    endfunction

    // Floor of the square root of an unsigned 128-bit discriminant.
    function automatic logic [63:0] floor_sqrt(logic [127:0] d);
        logic [63:0] r;
        logic [63:0] cand;
        r = 0;
        for (int i = 63; i >= 0; i--)
        begin
            cand = r | (64'd1 << i);
            if (128'(cand) * 128'(cand) <= d)
                r = cand;
        end
        return r;
    endfunction

    function automatic root_result_t predict_root(logic signed [CW-1:0] a,
                                                  logic signed [CW-1:0] b,
                                                  logic signed [CW-1:0] c);
        root_result_t        res;
        logic signed [127:0] disc;
        longint              s;
        longint              q1;
        longint              q2;
        longint              lo;
        longint              hi;
        res = '0;
        if (a == 0)
        begin
            res.degenerate = 1'b1;
            return res;
        end
        disc = 128'(b) * 128'(b) - 4 * 128'(a) * 128'(c);
        if (disc < 0)
            return res;
        if (disc == 0)
        begin
            lo = scaled_quotient(-longint'(b), a);
            if (lo > 0)
            begin
                res.root = CW'(lo);
                res.positive_count = 2'd1;
            end
        end
        else
        begin
            s = longint'(floor_sqrt(disc));
            q1 = scaled_quotient(-longint'(b) - s, a);
            q2 = scaled_quotient(-longint'(b) + s, a);
            lo = q1 < q2 ? q1 : q2;
            hi = q1 < q2 ? q2 : q1;
            if (lo > 0)
            begin
                res.root = CW'(lo);
                res.positive_count = 2'd2;
            end
            else if (hi > 0)
            begin
                res.root = CW'(hi);
                res.positive_count = 2'd1;
            end
        end
        res.found = res.positive_count != 0;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Offers one beat from the falling edge onward and holds it until it is taken.
    task automatic send_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                              logic signed [CW-1:0] c, bit has_fixed,
                              root_result_t fixed_res);
        root_result_t want;
        want = has_fixed ? fixed_res : predict_root(a, b, c);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({c, b, a});
        do
            @(posedge clk);
        while (!s_tready);
        pending_roots.push_back(want);
        @(negedge clk);
    endtask

    // Random burst gaps; the valid drops only when a gap is actually taken.
    task automatic sender_gap();
        int gap;
        if ($urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic logic signed [CW-1:0] random_coef();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? MAX_C : MIN_C;
            1: return CW'(signed'($urandom_range(0, 8)) - 4) <<< FB;
            2: return signed'(CW'($urandom_range(0, 2000))) - 1000;
            3: return $urandom_range(0, 7) == 0 ? '0 : signed'(CW'($urandom()));
            default: return signed'(CW'($urandom())) >>> $urandom_range(0, 16);
        endcase
    endfunction

    // Directed rows; a typed-in result is given where it is plain to see.
    coef_row_t directed_rows[$];

    task automatic add_row(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                           logic signed [CW-1:0] c, bit has_fixed, root_result_t r);
        coef_row_t row;
        row.a = a;
        row.b = b;
        row.c = c;
        row.has_fixed = has_fixed;
        row.fixed_res = r;
        directed_rows.push_back(row);
    endtask

    initial
    begin
        root_result_t degen_res;
        root_result_t none_res;
        degen_res = '0;
        degen_res.degenerate = 1'b1;
        none_res = '0;
        s_tvalid = 0;
        s_tdata  = '0;
        rst_n    = 0;
        // Coefficient a zero.
        add_row(0, ONE, ONE, 1, degen_res);
        add_row(0, MIN_C, MAX_C, 1, degen_res);
        // Negative discriminant: x^2 + 1.
        add_row(ONE, 0, ONE, 1, none_res);
        add_row(MAX_C, 0, MAX_C, 1, none_res);
        // Zero discriminant: (x-1)^2, and (x+1)^2 with no positive root.
        add_row(ONE, -2*ONE, ONE, 0, '0);
        add_row(ONE, 2*ONE, ONE, 0, '0);
        // Two positive roots, one positive root, and the same with a negative.
        add_row(ONE, -3*ONE, 2*ONE, 0, '0);
        add_row(ONE, -ONE, -2*ONE, 0, '0);
        add_row(-ONE, 3*ONE, -2*ONE, 0, '0);
        add_row(-ONE, ONE, 2*ONE, 0, '0);
        // Roots that truncate to zero and roots that saturate.
        add_row(MAX_C, 1, -1, 0, '0);
        add_row(1, MIN_C, 0, 0, '0);
        add_row(1, MAX_C, MIN_C, 0, '0);
        add_row(-1, MIN_C, MAX_C, 0, '0);
        // Extremes of every field, and small coefficients.
        add_row(MIN_C, MIN_C, MIN_C, 0, '0);
        add_row(MAX_C, MAX_C, MAX_C, 0, '0);
        add_row(MIN_C, MAX_C, MAX_C, 0, '0);
        add_row(MAX_C, MIN_C, MIN_C, 0, '0);
        add_row(-1, -1, -1, 0, '0);
        add_row(1, 0, 0, 0, '0);
        add_row(1, 0, -1, 0, '0);
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        foreach (directed_rows[i])
            send_coefs(directed_rows[i].a, directed_rows[i].b, directed_rows[i].c,
                       directed_rows[i].has_fixed, directed_rows[i].fixed_res);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            logic signed [CW-1:0] a;
            logic signed [CW-1:0] b;
            logic signed [CW-1:0] c;
            if (i == N_RANDOM / 2)
                long_hold = 1;
            a = random_coef();
            b = random_coef();
            c = random_coef();
            send_coefs(a, b, c, 0, '0);
            sender_gap();
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    // Receiver: randomly chosen stall patterns, plus one long hold-off requested by the stimulus.
    initial
    begin
        int mode;
        m_tready = 0;
        mode = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                long_hold = 0;
                m_tready <= 1'b0;
                repeat (3 * LATENCY) @(negedge clk);
            end
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= $urandom_range(0, 4) != 0;
            endcase
        end
    end

    // Output check at the rising edge.
    always @(posedge clk)
    begin
        root_result_t got;
        root_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = root_result_t'(m_tdata[CW+3:0]);
            if (pending_roots.size() == 0)
                report_mismatch("unexpected beat", 64'(m_tdata), 64'd0);
            else
            begin
                want = pending_roots.pop_front();
                if (got.found !== want.found)
                    report_mismatch("found", got.found, want.found);
                if (got.root !== want.root)
                    report_mismatch("root", got.root, want.root);
                if (got.positive_count !== want.positive_count)
                    report_mismatch("positive_count", got.positive_count,
                                    want.positive_count);
                if (got.degenerate !== want.degenerate)
                    report_mismatch("degenerate", got.degenerate, want.degenerate);
            end
        end
    end

    // Watchdog and end of run.
    initial
    begin
        @(posedge rst_n);
        while (!(stim_done && pending_roots.size() == 0) && idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
        end
        else
        begin
            repeat (2 * LATENCY) @(posedge clk);
            if (fail_count == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
        end
        $finish;
    end

endmodule
